@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FST_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FST_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fst_pkg.sv @@
// ----------------------------------------------------------------------------
// fst_pkg
// Shared sizes and record layouts of the flow statistics table.
// ----------------------------------------------------------------------------
package fst_pkg;

  // Number of flow slots in the table
  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);

  localparam int KEY_W   = 104;
  localparam int TIME_W  = 48;
  localparam int PKTS_W  = 32;
  localparam int BYTES_W = 48;
  localparam int LEN_W   = 16;
  localparam int OIDX_W  = 6;

  // Five-tuple flow key
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
  } fst_key_t;

  // One packet as it enters the lookup engine
  typedef struct packed {
    fst_key_t            key;
    logic [LEN_W-1:0]    len;
    logic [TIME_W-1:0]   ts;
  } fst_item_t;

  // One stored table entry; the last timestamp is always the current packet's
  typedef struct packed {
    fst_key_t            key;
    logic [TIME_W-1:0]   flow_start;
    logic [PKTS_W-1:0]   pkts;
    logic [BYTES_W-1:0]  bytes;
  } fst_entry_t;

  // One result record handed from the engine to the output register
  typedef struct packed {
    logic                hit;
    logic                table_full;
    logic [OIDX_W-1:0]   entry_index;
    logic [PKTS_W-1:0]   pkt_count;
    logic [BYTES_W-1:0]  byte_count;
    logic [TIME_W-1:0]   duration_us;
  } fst_result_t;

endpackage

@@ sv/flow_statistics_table_top.sv @@
// ----------------------------------------------------------------------------
// flow_statistics_table_top
// Five-tuple flow cache: per-packet lookup in a 64-slot table with saturating
// packet and byte counters and flow duration.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid_i/in_stall_o  src_ip .. timestamp_us
//   out      source     out_valid_o/out_stall_i hit .. duration_us
//
// A packet holds the engine from its transfer until its result moves to the
// output register, and the next packet waits until then; a hit ends the
// scan early and a dropped flow skips the write. The single read port of
// the flow memory scans one claimed slot per cycle.
// Reset empties the table at once: slots are claimed in ascending order, so
// the fill count alone marks which slots are live.
// A finished result waits in the output register while the next packet is
// taken in; the engine holds a second result until that register frees up.
// ----------------------------------------------------------------------------
module flow_statistics_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  proto_i,
  input  logic [15:0] pkt_len_i,
  input  logic [47:0] timestamp_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        table_full_o,
  output logic [5:0]  entry_index_o,
  output logic [31:0] pkt_count_o,
  output logic [47:0] byte_count_o,
  output logic [47:0] duration_us_o
);
  import fst_pkg::*;

  logic        idle;
  logic        in_xfer;
  fst_item_t   item;
  logic        res_valid;
  fst_result_t res;
  logic        res_load;
  logic        out_valid_q, out_valid_d;
  fst_result_t out_q;

  // Accept a packet whenever the engine is free
  assign in_stall_o = !idle;
  assign in_xfer    = in_valid_i && idle;

  assign item.key.src_ip   = src_ip_i;
  assign item.key.dst_ip   = dst_ip_i;
  assign item.key.src_port = src_port_i;
  assign item.key.dst_port = dst_port_i;
  assign item.key.proto    = proto_i;
  assign item.len          = pkt_len_i;
  assign item.ts           = timestamp_us_i;

  fst_engine u_fst_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .item_i      (item),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_load)
  );

  // Load the output register when it is empty or being drained
  assign res_load    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_q.hit;
  assign table_full_o  = out_q.table_full;
  assign entry_index_o = out_q.entry_index;
  assign pkt_count_o   = out_q.pkt_count;
  assign byte_count_o  = out_q.byte_count;
  assign duration_us_o = out_q.duration_us;

endmodule

@@ sv/fst_ram.sv @@
// ----------------------------------------------------------------------------
// fst_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module fst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, else read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fst_engine.sv @@
// ----------------------------------------------------------------------------
// fst_engine
// Sequencer that scans the flow memory for a key, then claims or updates an
// entry and forms the statistics result.
// ----------------------------------------------------------------------------
module fst_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fst_pkg::fst_item_t  item_i,
  output logic                idle_o,
  output logic                res_valid_o,
  output fst_pkg::fst_result_t res_o,
  input  logic                res_take_i
);
  import fst_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic                rvalid_q, rvalid_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  fst_item_t           item_q, item_d;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic [TIME_W-1:0]   first_q, first_d;
  logic [PKTS_W-1:0]   pkts_q, pkts_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;
  fst_result_t         res_q, res_d;

  logic                ram_en, ram_we;
  logic [IDX_W-1:0]    ram_addr;
  fst_entry_t          ram_wdata, ram_rdata;

  logic                key_match;
  logic                scan_end;
  logic [PKTS_W-1:0]   pkts_new;
  logic [BYTES_W:0]    bytes_sum;
  logic [BYTES_W-1:0]  bytes_new;
  logic [TIME_W-1:0]   duration;

  fst_ram #(
    .DEPTH (FLOW_ENTRIES),
    .WIDTH ($bits(fst_entry_t))
  ) u_fst_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Compare the entry read last cycle; claimed slots are exactly 0..used-1
  assign key_match = rvalid_q && (ram_rdata.key == item_q.key);
  assign scan_end  = (issue_q >= used_q);

  // Saturating counter updates and flow duration
  assign pkts_new  = (pkts_q == {PKTS_W{1'b1}}) ? pkts_q : pkts_q + PKTS_W'(1);
  assign bytes_sum = {1'b0, bytes_q} + (BYTES_W + 1)'(item_q.len);
  assign bytes_new = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : bytes_sum[BYTES_W-1:0];
  assign duration  = item_q.ts - first_q;

  // Drive the memory port: reads while scanning, one write on update
  always_comb begin
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = issue_q[IDX_W-1:0];
    ram_wdata.key        = item_q.key;
    ram_wdata.flow_start = first_q;
    ram_wdata.pkts       = pkts_new;
    ram_wdata.bytes      = bytes_new;
    case (state_q)
      ST_SCAN: begin
        ram_en = !scan_end;
      end
      ST_UPDATE: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = slot_q;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    issue_d   = issue_q;
    rvalid_d  = 1'b0;
    cmp_idx_d = cmp_idx_q;
    item_d    = item_q;
    hit_d     = hit_q;
    slot_d    = slot_q;
    first_d   = first_q;
    pkts_d    = pkts_q;
    bytes_d   = bytes_q;
    res_d     = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_d  = item_i;
          issue_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Advance the read pointer one entry per cycle
        if (!scan_end) begin
          issue_d   = issue_q + CNT_W'(1);
          rvalid_d  = 1'b1;
          cmp_idx_d = issue_q[IDX_W-1:0];
        end
        if (key_match) begin
          hit_d   = 1'b1;
          slot_d  = cmp_idx_q;
          first_d = ram_rdata.flow_start;
          pkts_d  = ram_rdata.pkts;
          bytes_d = ram_rdata.bytes;
          state_d = ST_UPDATE;
        end else if (scan_end) begin
          if (used_q == CNT_W'(FLOW_ENTRIES)) begin
            // Drop the new flow: no free slot
            res_d             = '0;
            res_d.table_full  = 1'b1;
            state_d           = ST_DONE;
          end else begin
            // Claim the next free slot
            hit_d   = 1'b0;
            slot_d  = used_q[IDX_W-1:0];
            first_d = item_q.ts;
            pkts_d  = '0;
            bytes_d = '0;
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (!hit_q) begin
          used_d = used_q + CNT_W'(1);
        end
        res_d.hit         = hit_q;
        res_d.table_full  = 1'b0;
        res_d.entry_index = OIDX_W'(slot_q);
        res_d.pkt_count   = pkts_new;
        res_d.byte_count  = bytes_new;
        res_d.duration_us = duration;
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      issue_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      issue_q  <= issue_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    item_q    <= item_d;
    hit_q     <= hit_d;
    slot_q    <= slot_d;
    first_q   <= first_d;
    pkts_q    <= pkts_d;
    bytes_q   <= bytes_d;
    res_q     <= res_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

@@ sv/fst_checker.sv @@
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks of the flow statistics table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic        table_full_o,
  input logic [5:0]  entry_index_o,
  input logic [31:0] pkt_count_o,
  input logic [47:0] byte_count_o,
  input logic [47:0] duration_us_o
);

  // Hold a stalled result
  `FST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pkt_count_o) && $stable(byte_count_o) && $stable(entry_index_o), "stalled result changed")

  // A transfer in keeps the engine busy through the next cycle
  `FST_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "engine free right after a packet transfer")

  // A dropped flow reports all-zero statistics
  `FST_ASSERT_IMPL(a_drop_zero, clk_i, rst_ni, out_valid_o && table_full_o, !hit_o && (entry_index_o == 6'd0) && (pkt_count_o == 32'd0) && (byte_count_o == 48'd0) && (duration_us_o == 48'd0), "dropped flow with nonzero statistics")

  // A recorded flow has counted at least this packet
  `FST_ASSERT_IMPL(a_count_nonzero, clk_i, rst_ni, out_valid_o && !table_full_o, pkt_count_o != 32'd0, "recorded flow with zero packet count")

endmodule

bind flow_statistics_table_top fst_checker u_fst_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Packet-level check of the flow statistics table. A queue of packets feeds a
// valid/stall driver; a monitor predicts each result from its own copy of the
// flow table and compares every transfer on the result channel field by
// field. Directed packets cover key, length and time extremes; random packets
// mix new flows, near-miss keys and repeat hits, then keep hammering a full
// table.
// ----------------------------------------------------------------------------
module testbench;
  import fst_pkg::*;

  localparam int     IDLE_PCT     = 11;
  localparam int     RANDOM_PKTS  = 1900;
  localparam int     DRAIN_CYCLES = 200;
  localparam int     QUIET_FROM   = 40_000;
  localparam int     QUIET_TO     = 70_000;
  localparam longint CYCLE_LIMIT  = 1_000_000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [31:0] src_ip_i       = '0;
  logic [31:0] dst_ip_i       = '0;
  logic [15:0] src_port_i     = '0;
  logic [15:0] dst_port_i     = '0;
  logic [7:0]  proto_i        = '0;
  logic [15:0] pkt_len_i      = '0;
  logic [47:0] timestamp_us_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        hit_o;
  logic        table_full_o;
  logic [5:0]  entry_index_o;
  logic [31:0] pkt_count_o;
  logic [47:0] byte_count_o;
  logic [47:0] duration_us_o;

  fst_item_t   pkt_queue[$];
  fst_result_t flow_expect[$];
  fst_key_t    flow_keys[$];
  logic        in_fire   = 1'b0;
  longint      cycle_cnt = 0;
  int          err_cnt   = 0;
  logic [TIME_W-1:0] now_us = '0;

  // Shadow flow table
  bit                 slot_live  [FLOW_ENTRIES];
  fst_key_t           slot_key   [FLOW_ENTRIES];
  logic [TIME_W-1:0]  slot_first [FLOW_ENTRIES];
  logic [PKTS_W-1:0]  slot_pkts  [FLOW_ENTRIES];
  logic [BYTES_W-1:0] slot_bytes [FLOW_ENTRIES];
  int                 slots_used = 0;

  flow_statistics_table_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .src_ip_i       (src_ip_i),
    .dst_ip_i       (dst_ip_i),
    .src_port_i     (src_port_i),
    .dst_port_i     (dst_port_i),
    .proto_i        (proto_i),
    .pkt_len_i      (pkt_len_i),
    .timestamp_us_i (timestamp_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .table_full_o   (table_full_o),
    .entry_index_o  (entry_index_o),
    .pkt_count_o    (pkt_count_o),
    .byte_count_o   (byte_count_o),
    .duration_us_o  (duration_us_o)
  );

  // Look up the flow, claim a slot on a miss, update the counters
  function automatic fst_result_t flow_update(fst_item_t pkt);
    fst_result_t      res;
    int               slot;
    logic             found;
    logic [BYTES_W:0] sum;
    res   = '0;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (!found && slot_live[i] && slot_key[i] == pkt.key) begin
        slot  = i;
        found = 1'b1;
      end
    end
    // Drop a new flow when every slot is taken
    if (!found && slots_used >= FLOW_ENTRIES) begin
      res.table_full = 1'b1;
      return res;
    end
    if (!found) begin
      slot             = slots_used;
      slots_used       = slots_used + 1;
      slot_live[slot]  = 1'b1;
      slot_key[slot]   = pkt.key;
      slot_first[slot] = pkt.ts;
      slot_pkts[slot]  = '0;
      slot_bytes[slot] = '0;
    end
    // Saturate both counters
    if (slot_pkts[slot] != '1) slot_pkts[slot] = slot_pkts[slot] + 1'b1;
    sum = slot_bytes[slot] + pkt.len;
    slot_bytes[slot] = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
    res.hit         = found;
    res.entry_index = OIDX_W'(slot);
    res.pkt_count   = slot_pkts[slot];
    res.byte_count  = slot_bytes[slot];
    res.duration_us = pkt.ts - slot_first[slot];
    return res;
  endfunction

  function automatic fst_key_t rand_key();
    fst_key_t k;
    k.src_ip   = $urandom;
    k.dst_ip   = $urandom;
    k.src_port = 16'($urandom);
    k.dst_port = 16'($urandom);
    k.proto    = 8'($urandom);
    return k;
  endfunction

  // Favor the flows that got a slot, sometimes pick a dropped one
  function automatic fst_key_t pick_flow();
    if (flow_keys.size() > FLOW_ENTRIES && $urandom_range(3) != 0)
      return flow_keys[$urandom_range(FLOW_ENTRIES - 1)];
    return flow_keys[$urandom_range(flow_keys.size() - 1)];
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '1;
    if (roll < 12) return '0;
    return LEN_W'($urandom);
  endfunction

  // Mostly move time forward, now and then jump anywhere, backwards included
  function automatic logic [TIME_W-1:0] next_time();
    if ($urandom_range(99) < 3) now_us = TIME_W'({$urandom, $urandom});
    else now_us = now_us + $urandom_range(2000);
    return now_us;
  endfunction

  function automatic void send(fst_key_t k, logic [LEN_W-1:0] len,
                               logic [TIME_W-1:0] ts);
    fst_item_t pkt;
    pkt.key = k;
    pkt.len = len;
    pkt.ts  = ts;
    pkt_queue.push_back(pkt);
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  always #2 clk_i = ~clk_i;

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drive packets and result-side stall at the falling edge
  always @(negedge clk_i) begin : driver
    fst_item_t nxt;
    logic      quiet;
    quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);
    if (rst_ni) begin
      out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
      if (!in_valid_i || in_fire) begin
        if (pkt_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pkt_queue.pop_front();
          src_ip_i       <= nxt.key.src_ip;
          dst_ip_i       <= nxt.key.dst_ip;
          src_port_i     <= nxt.key.src_port;
          dst_port_i     <= nxt.key.dst_port;
          proto_i        <= nxt.key.proto;
          pkt_len_i      <= nxt.len;
          timestamp_us_i <= nxt.ts;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Predict on each packet transfer, check each result transfer
  always @(posedge clk_i) begin : monitor
    fst_item_t   pkt;
    fst_result_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        pkt.key.src_ip   = src_ip_i;
        pkt.key.dst_ip   = dst_ip_i;
        pkt.key.src_port = src_port_i;
        pkt.key.dst_port = dst_port_i;
        pkt.key.proto    = proto_i;
        pkt.len          = pkt_len_i;
        pkt.ts           = timestamp_us_i;
        flow_expect.push_back(flow_update(pkt));
      end
      if (out_valid_o && !out_stall_i) begin
        if (flow_expect.size() == 0) begin
          $error("result transfer with no packet pending");
          err_cnt++;
        end else begin
          want = flow_expect.pop_front();
          check_field("hit", 48'(want.hit), 48'(hit_o));
          check_field("table_full", 48'(want.table_full), 48'(table_full_o));
          check_field("entry_index", 48'(want.entry_index), 48'(entry_index_o));
          check_field("pkt_count", 48'(want.pkt_count), 48'(pkt_count_o));
          check_field("byte_count", want.byte_count, byte_count_o);
          check_field("duration_us", want.duration_us, duration_us_o);
        end
      end
    end
  end

  initial begin : stimulus
    fst_key_t k;
    int       roll;

    // Key, length and time extremes on an empty table
    send('0, '0, '0);
    send('0, '1, '1);
    send('1, '1, 48'd5);
    send('1, 16'd1, 48'd3);
    flow_keys.push_back('0);
    flow_keys.push_back('1);

    // Step away from the all-zero key one field at a time
    k = '0; k.src_ip   = 32'h8000_0001; send(k, 16'd64, 48'd10); flow_keys.push_back(k);
    k = '0; k.dst_ip   = 32'h8000_0001; send(k, 16'd64, 48'd11); flow_keys.push_back(k);
    k = '0; k.src_port = 16'h8001;      send(k, 16'd64, 48'd12); flow_keys.push_back(k);
    k = '0; k.dst_port = 16'h8001;      send(k, 16'd64, 48'd13); flow_keys.push_back(k);
    k = '0; k.proto    = 8'h81;         send(k, 16'd64, 48'd14); flow_keys.push_back(k);
    send(k, 16'hFFFF, 48'd20);
    send('0, 16'd1500, 48'd30);
    send('1, '0, '1);
    now_us = 48'd1000;

    // Random mix: new flows, near-miss keys, repeat hits
    for (int n = 0; n < RANDOM_PKTS; n++) begin
      roll = $urandom_range(99);
      if (roll < 22) begin
        k = rand_key();
        flow_keys.push_back(k);
      end else if (roll < 32) begin
        k = pick_flow();
        k = k ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
        flow_keys.push_back(k);
      end else begin
        k = pick_flow();
      end
      send(k, rand_len(), next_time());
    end

    // Hold reset, then release it away from the rising edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every packet and result, then let the pipe drain
    while (pkt_queue.size() != 0 || in_valid_i || flow_expect.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
